/* design/mhe_pkg.sv */
// ----------------------------------------------------------------------------
// mhe_pkg
// Shared widths, request codes and status codes of the max-heap engine.
// ----------------------------------------------------------------------------
package mhe_pkg;

  localparam int DATA_W       = 32;
  localparam int REQ_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 7;
  localparam int DEF_CAPACITY = 64;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_REMOVE = 2'd1;
  localparam req_t REQ_SORT   = 2'd2;
  localparam req_t REQ_DUMP   = 2'd3;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_MISSING = 2'd2;
  localparam status_t ST_EMPTY   = 2'd3;

endpackage

/* design/mhe_if.sv */
// ----------------------------------------------------------------------------
// mhe channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhe_req_if
  import mhe_pkg::*;
();
  logic                     valid;
  logic                     ready;
  req_t                     req_type;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

interface mhe_rsp_if
  import mhe_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_value;
  status_t                  status;
  logic                     last;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, out_value, status, last, count, input ready);
  modport sink   (input valid, out_value, status, last, count, output ready);
endinterface

/* design/max_heap_engine.sv */
// ----------------------------------------------------------------------------
// max_heap_engine
// Binary max-heap of signed 32-bit values in one synchronous memory, with
// insert, remove-first-match, heapsort readout and dump.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request channel (req_type, value). A transfer is taken only while
//          the engine is idle; one request is worked at a time.
//   rsp  : response channel (out_value, status, last, count). Insert and
//          remove give one transfer; sort and dump give one per held entry,
//          or one transfer with status empty when the heap is empty.
// Timing: every memory read is registered, so each heap level walked takes
//   a read state and a compare state on sift-up, and a left-read, a
//   right-read and a compare state on sift-down. Every emitted entry of sort
//   or dump takes a read state and an output state, which waits for a free
//   output register. The single read port of the memory sets this pacing.
// Reset: the entry count clears at once; the store is not cleared, since
//   only entries written since reset are ever used.
// Stall: a result sits in the output register until rsp.ready; the engine
//   waits only to load its next result, and accepts the next request once
//   its own work is done.
module max_heap_engine
  import mhe_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input logic         clk,
  input logic         rst,
  mhe_req_if.sink     req,
  mhe_rsp_if.source   rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 2;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RESP   = 5'd1;
  localparam logic [4:0] S_SU_RD  = 5'd2;
  localparam logic [4:0] S_SU_CMP = 5'd3;
  localparam logic [4:0] S_WR_FIN = 5'd4;
  localparam logic [4:0] S_SR_RD  = 5'd5;
  localparam logic [4:0] S_SR_CMP = 5'd6;
  localparam logic [4:0] S_RM_RDL = 5'd7;
  localparam logic [4:0] S_RM_GET = 5'd8;
  localparam logic [4:0] S_SD_CHK = 5'd9;
  localparam logic [4:0] S_SD_RR  = 5'd10;
  localparam logic [4:0] S_SD_CMP = 5'd11;
  localparam logic [4:0] S_SO_RD0 = 5'd12;
  localparam logic [4:0] S_SO_RDE = 5'd13;
  localparam logic [4:0] S_SO_SW  = 5'd14;
  localparam logic [4:0] S_SO_NXT = 5'd15;
  localparam logic [4:0] S_EM_RD  = 5'd16;
  localparam logic [4:0] S_EM_OUT = 5'd17;

  // Heap storage
  logic [DATA_W-1:0] heap_store [CAPACITY];
  logic [DATA_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  // Control and working registers
  logic [4:0]               state;
  req_t                     op;
  logic [CW-1:0]            cnt;
  logic [AW-1:0]            idx;
  logic signed [DATA_W-1:0] val;
  logic [DATA_W-1:0]        lval;
  logic [DATA_W-1:0]        top;
  logic [CW-1:0]            lim;
  logic [AW-1:0]            endi;
  logic [CW-1:0]            em_n;
  logic                     first;
  status_t                  rsp_status;

  // Output register
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  status_t                  out_status;
  logic                     out_last;
  logic [COUNT_W-1:0]       out_count;
  logic                     out_free;
  logic                     out_load;

  // Derived indexes
  logic [AW-1:0] parent;
  logic [LW-1:0] lchild;
  logic [LW-1:0] rchild;
  logic [LW-1:0] lim_x;
  logic          l_in;
  logic          r_in;
  logic          l_up;
  logic          r_up;
  logic          em_last;

  assign parent  = (idx - AW'(1)) >> 1;
  assign lchild  = {1'b0, idx, 1'b1};
  assign rchild  = lchild + LW'(1);
  assign lim_x   = LW'(lim);
  assign l_in    = lchild < lim_x;
  assign r_in    = rchild < lim_x;
  assign l_up    = $signed(lval) > val;
  assign r_up    = r_in && ($signed(rd_data) > (l_up ? $signed(lval) : val));
  assign em_last = (CW'(idx) + CW'(1)) == em_n;
  assign out_free = !out_valid || rsp.ready;
  assign out_load = out_free && ((state == S_RESP) || (state == S_EM_OUT));

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.out_value = out_value;
  assign rsp.status    = out_status;
  assign rsp.last      = out_last;
  assign rsp.count     = out_count;

  // Select the read address
  always_comb begin
    case (state)
      S_SU_RD:  rd_addr = parent;
      S_SR_RD:  rd_addr = idx;
      S_RM_RDL: rd_addr = AW'(cnt);
      S_SD_CHK: rd_addr = lchild[AW-1:0];
      S_SD_RR:  rd_addr = rchild[AW-1:0];
      S_SO_RD0: rd_addr = '0;
      S_SO_RDE: rd_addr = endi;
      default:  rd_addr = idx;
    endcase
  end

  // Select the write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = val;
    case (state)
      S_SU_CMP: begin
        wr_en   = val > $signed(rd_data);
        wr_data = rd_data;
      end
      S_WR_FIN: wr_en = 1'b1;
      S_SD_CMP: begin
        wr_en   = l_up || r_up;
        wr_data = r_up ? rd_data : lval;
      end
      S_SO_SW: begin
        wr_en   = 1'b1;
        wr_addr = endi;
        wr_data = top;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_store[wr_addr] <= wr_data;
    end
    rd_data <= heap_store[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      first <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op  <= req.req_type;
            val <= req.value;
            idx <= '0;
            case (req.req_type)
              REQ_INSERT: begin
                if (cnt == CW'(CAPACITY)) begin
                  rsp_status <= ST_FULL;
                  state      <= S_RESP;
                end else begin
                  rsp_status <= ST_OK;
                  idx        <= AW'(cnt);
                  cnt        <= cnt + CW'(1);
                  first      <= 1'b0;
                  state      <= (cnt == '0) ? S_WR_FIN : S_SU_RD;
                end
              end
              REQ_REMOVE: begin
                if (cnt == '0) begin
                  rsp_status <= ST_MISSING;
                  state      <= S_RESP;
                end else begin
                  rsp_status <= ST_OK;
                  state      <= S_SR_RD;
                end
              end
              default: begin
                if (cnt == '0) begin
                  rsp_status <= ST_EMPTY;
                  state      <= S_RESP;
                end else begin
                  em_n <= cnt;
                  endi <= AW'(cnt - CW'(1));
                  if (req.req_type == REQ_SORT) begin
                    cnt   <= '0;
                    state <= (cnt == CW'(1)) ? S_EM_RD : S_SO_RD0;
                  end else begin
                    state <= S_EM_RD;
                  end
                end
              end
            endcase
          end
        end

        // Walk toward the root, moving smaller parents down
        S_SU_RD: state <= S_SU_CMP;
        S_SU_CMP: begin
          if (val > $signed(rd_data)) begin
            idx   <= parent;
            first <= 1'b0;
            state <= (parent == '0) ? S_WR_FIN : S_SU_RD;
          end else if (first) begin
            first <= 1'b0;
            state <= S_SD_CHK;
          end else begin
            state <= S_WR_FIN;
          end
        end

        // Drop the moving value into its hole
        S_WR_FIN: state <= (op == REQ_SORT) ? S_SO_NXT : S_RESP;

        // Search in index order for the first match
        S_SR_RD: state <= S_SR_CMP;
        S_SR_CMP: begin
          if ($signed(rd_data) == val) begin
            cnt   <= cnt - CW'(1);
            state <= (CW'(idx) == cnt - CW'(1)) ? S_RESP : S_RM_RDL;
          end else if (CW'(idx) + CW'(1) == cnt) begin
            rsp_status <= ST_MISSING;
            state      <= S_RESP;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_SR_RD;
          end
        end

        // Fetch the last entry to refill the hole
        S_RM_RDL: state <= S_RM_GET;
        S_RM_GET: begin
          val <= rd_data;
          lim <= cnt;
          if (idx != '0) begin
            first <= 1'b1;
            state <= S_SU_RD;
          end else begin
            state <= S_SD_CHK;
          end
        end

        // Walk toward the leaves, moving the larger child up
        S_SD_CHK: state <= l_in ? S_SD_RR : S_WR_FIN;
        S_SD_RR: begin
          lval  <= rd_data;
          state <= S_SD_CMP;
        end
        S_SD_CMP: begin
          if (r_up) begin
            idx   <= rchild[AW-1:0];
            state <= S_SD_CHK;
          end else if (l_up) begin
            idx   <= lchild[AW-1:0];
            state <= S_SD_CHK;
          end else begin
            state <= S_WR_FIN;
          end
        end

        // Heapsort: swap root with the end, sift the end value down
        S_SO_RD0: state <= S_SO_RDE;
        S_SO_RDE: begin
          top   <= rd_data;
          state <= S_SO_SW;
        end
        S_SO_SW: begin
          val   <= rd_data;
          idx   <= '0;
          lim   <= CW'(endi);
          state <= S_SD_CHK;
        end
        S_SO_NXT: begin
          if (endi == AW'(1)) begin
            idx   <= '0;
            state <= S_EM_RD;
          end else begin
            endi  <= endi - AW'(1);
            state <= S_SO_RD0;
          end
        end

        // Emit entries in index order
        S_EM_RD: state <= S_EM_OUT;
        S_EM_OUT: begin
          if (out_free) begin
            if (em_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_EM_RD;
            end
          end
        end

        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load when free, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count <= COUNT_W'(cnt);
      if (state == S_EM_OUT) begin
        out_value  <= rd_data;
        out_status <= ST_OK;
        out_last   <= em_last;
      end else begin
        out_value  <= '0;
        out_status <= rsp_status;
        out_last   <= 1'b1;
      end
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("request taken without work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(out_valid && !rsp.ready))
    else $error("pending result overwritten");

endmodule
